/* rtl/cst_pkg.sv */
package cst_pkg;

    localparam int MAX_PANELS_DEF = 64;
    localparam int PANEL_W        = 7;
    localparam int ENTRY_W        = 6;
    localparam int SIZE_W         = 13;
    localparam int CFG_W          = 7;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PANELS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS  = 1'd1;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_HEADER   = 2'd1,
        CMD_SEG_DONE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_RECV     = 2'd1,
        ACT_OWN_SEND = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD,
        ST_SCAN
    } state_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ENTRY_W-1:0]  entry_index;
        logic [SIZE_W-1:0]   entry_fwd_bytes;
        logic [SIZE_W-1:0]   entry_ret_bytes;
    } item_t;

    typedef struct packed {
        action_t             action;
        logic [SIZE_W-1:0]   byte_count;
        logic                own_segment;
        logic                in_return_phase;
        logic [PANEL_W-1:0]  next_panel;
    } result_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   fwd;
        logic [SIZE_W-1:0]   ret;
    } entry_t;

    typedef struct packed {
        logic                we;
        logic [ENTRY_W-1:0]  windex;
        entry_t              wdata;
        logic [PANEL_W-1:0]  rindex;
    } tbl_req_t;

endpackage

/* rtl/chain_slot_tracker.sv */
// Chain slot tracker: follows which panel's segment is on the shared chain bus.
// Command channel: an item transfers on a clock edge with start high and busy
// low. Load commands fill the per-panel forward/return size table, a header
// restarts the forward phase at panel 0, and a segment-done command advances
// to the next panel or, in the return phase, to the next panel with return data.
// Every command yields one result, shown on result for exactly one cycle with
// done high; the receiver cannot stall, so it must take it in that cycle.
// A load or an unused command issues its result straight from the accepting
// state; a header or a forward step first reads the table in ST_FWD. A step
// that scans return sizes visits table entries in ST_SCAN (at most the panel
// count) and issues its result from there when it finds a panel, or through
// ST_FWD when it finds none. The scan reads one table entry per cycle.
// busy stays high from accept until the result is issued (a load or an unused
// command never raises it); a new command can transfer in the cycle done shows.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only happen while the block is idle.
// Reset returns to the forward phase at panel 0 with a panel count of 1 and
// own address 0; table contents are undefined until loaded.
module chain_slot_tracker #(
    parameter int MAX_PANELS = cst_pkg::MAX_PANELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cst_pkg::item_t                item,
    output logic                          done,
    output cst_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cst_pkg::CFG_W-1:0]     cfg_data
);
    import cst_pkg::*;

    logic [PANEL_W-1:0] total_panels_reg;
    logic [ENTRY_W-1:0] own_address_reg;
    logic [PANEL_W-1:0] total_eff;
    tbl_req_t           req;
    entry_t             rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_panels_reg <= PANEL_W'(1);
            own_address_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL_PANELS: total_panels_reg <= cfg_data[PANEL_W-1:0];
                CFG_OWN_ADDRESS:  own_address_reg  <= cfg_data[ENTRY_W-1:0];
                default:          own_address_reg  <= own_address_reg;
            endcase
        end
    end

    // limit the panel count to the table depth
    assign total_eff = (32'(total_panels_reg) > MAX_PANELS) ? PANEL_W'(MAX_PANELS)
                                                             : total_panels_reg;

    cst_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .total       (total_eff),
        .own_address (own_address_reg),
        .rdata       (rdata),
        .req         (req),
        .busy        (busy),
        .done        (done),
        .result      (result)
    );

    cst_table #(
        .MAX_PANELS (MAX_PANELS)
    ) u_table (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

endmodule

/* rtl/cst_table.sv */
module cst_table #(
    parameter int MAX_PANELS = cst_pkg::MAX_PANELS_DEF
) (
    input  logic              clk,
    input  cst_pkg::tbl_req_t req,
    output cst_pkg::entry_t   rdata
);
    import cst_pkg::*;

    localparam int AW = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;

    entry_t               mem [MAX_PANELS];
    logic [PANEL_W+AW-1:0] rext;
    logic [ENTRY_W+AW-1:0] wext;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         waddr;
    logic                  wr_ok;
    entry_t                rdata_reg;

    assign rext  = {{AW{1'b0}}, req.rindex};
    assign wext  = {{AW{1'b0}}, req.windex};
    assign raddr = rext[AW-1:0];
    assign waddr = wext[AW-1:0];
    // drop loads that land beyond the table
    assign wr_ok = req.we && (32'(req.windex) < MAX_PANELS);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[waddr] <= req.wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/cst_seq.sv */
module cst_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  cst_pkg::item_t              item,
    input  logic [cst_pkg::PANEL_W-1:0] total,
    input  logic [cst_pkg::ENTRY_W-1:0] own_address,
    input  cst_pkg::entry_t             rdata,
    output cst_pkg::tbl_req_t           req,
    output logic                        busy,
    output logic                        done,
    output cst_pkg::result_t            result
);
    import cst_pkg::*;

    state_t               state_reg, state_next;
    logic [PANEL_W-1:0]   panel_reg, panel_next;
    logic                 rp_reg, rp_next;
    logic [PANEL_W-1:0]   chk_reg, chk_next;
    logic                 own_reg, own_next;
    result_t              result_reg, result_next;
    logic                 done_reg, done_next;

    logic                 accept;
    logic                 go_fwd;
    logic                 go_scan;
    logic                 finish;
    logic                 scan_req;
    logic [PANEL_W-1:0]   scan_from;
    logic [PANEL_W:0]     panel_inc;
    logic [PANEL_W:0]     chk_inc;
    logic [PANEL_W:0]     total_ext;
    logic [PANEL_W-1:0]   own_ext;

    assign accept    = start && (state_reg == ST_IDLE);
    assign panel_inc = {1'b0, panel_reg} + 1'b1;
    assign chk_inc   = {1'b0, chk_reg} + 1'b1;
    assign total_ext = {1'b0, total};
    assign own_ext   = {1'b0, own_address};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (go_scan)
                begin
                    state_next = ST_SCAN;
                end
                else if (go_fwd)
                begin
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
                else if (go_fwd)
                begin
                    state_next = ST_FWD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        panel_next  = panel_reg;
        rp_next     = rp_reg;
        chk_next    = chk_reg;
        own_next    = own_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        go_fwd      = 1'b0;
        go_scan     = 1'b0;
        finish      = 1'b0;
        scan_req    = 1'b0;
        scan_from   = '0;
        req.we      = 1'b0;
        req.windex  = item.entry_index;
        req.wdata   = '{fwd: item.entry_fwd_bytes, ret: item.entry_ret_bytes};
        req.rindex  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    own_next = 1'b0;
                    unique case (item.cmd)
                        CMD_LOAD:
                        begin
                            req.we = 1'b1;
                            finish = 1'b1;
                        end
                        CMD_HEADER:
                        begin
                            panel_next = '0;
                            rp_next    = 1'b0;
                            go_fwd     = 1'b1;
                        end
                        CMD_SEG_DONE:
                        begin
                            if (!rp_reg)
                            begin
                                own_next = (panel_reg == own_ext);
                                if (panel_inc >= total_ext)
                                begin
                                    rp_next  = 1'b1;
                                    scan_req = 1'b1;
                                end
                                else
                                begin
                                    panel_next = panel_inc[PANEL_W-1:0];
                                    req.rindex = panel_inc[PANEL_W-1:0];
                                    go_fwd     = 1'b1;
                                end
                            end
                            else
                            begin
                                scan_req  = 1'b1;
                                scan_from = panel_reg;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                    // scan that starts past the last panel finds nothing
                    if (scan_req)
                    begin
                        if ({1'b0, scan_from} >= total_ext)
                        begin
                            panel_next = '0;
                            rp_next    = 1'b0;
                            req.rindex = '0;
                            go_fwd     = 1'b1;
                        end
                        else
                        begin
                            chk_next   = scan_from;
                            req.rindex = scan_from;
                            go_scan    = 1'b1;
                        end
                    end
                    if (finish)
                    begin
                        done_next   = 1'b1;
                        result_next = '{action: ACT_NONE, byte_count: '0, own_segment: 1'b0,
                                        in_return_phase: rp_reg, next_panel: panel_reg};
                    end
                end
            end
            ST_FWD:
            begin
                done_next   = 1'b1;
                result_next = '{action: ACT_RECV, byte_count: rdata.fwd,
                                own_segment: own_reg, in_return_phase: rp_reg,
                                next_panel: panel_reg};
            end
            ST_SCAN:
            begin
                if (rdata.ret != '0)
                begin
                    finish      = 1'b1;
                    panel_next  = chk_inc[PANEL_W-1:0];
                    done_next   = 1'b1;
                    result_next = '{action: (chk_reg == own_ext) ? ACT_OWN_SEND : ACT_RECV,
                                    byte_count: rdata.ret, own_segment: own_reg,
                                    in_return_phase: rp_reg,
                                    next_panel: chk_inc[PANEL_W-1:0]};
                end
                else if (chk_inc >= total_ext)
                begin
                    // no return data left: back to the forward phase
                    panel_next = '0;
                    rp_next    = 1'b0;
                    req.rindex = '0;
                    go_fwd     = 1'b1;
                end
                else
                begin
                    chk_next   = chk_inc[PANEL_W-1:0];
                    req.rindex = chk_inc[PANEL_W-1:0];
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            panel_reg <= '0;
            rp_reg    <= 1'b0;
            chk_reg   <= '0;
            own_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            panel_reg <= panel_next;
            rp_reg    <= rp_next;
            chk_reg   <= chk_next;
            own_reg   <= own_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/cst_checker.sv */
module cst_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  cst_pkg::item_t   item,
    input  logic             done,
    input  cst_pkg::result_t result
);
    import cst_pkg::*;

    // a result is never issued while a command is still in progress
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result issued while busy");

    // a load completes on the next cycle
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_LOAD) |=> (done && !busy))
        else $error("load did not complete in one cycle");

    // an accepted command either keeps the block busy or finishes at once
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command vanished");

    // the own transmit slot only exists in the return phase
    a_own_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.action == ACT_OWN_SEND) |-> result.in_return_phase)
        else $error("own slot outside return phase");

    // no action means no expected bytes
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.action == ACT_NONE) |-> (result.byte_count == '0))
        else $error("byte count without action");

endmodule

bind chain_slot_tracker cst_checker u_cst_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
    import cst_pkg::*;

    localparam int    TBL_DEPTH  = MAX_PANELS_DEF;
    localparam int    CYCLE_CAP  = 500000;
    localparam cmd_t  CMD_UNUSED = cmd_t'(2'd3);

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    item_t                item  = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    chain_slot_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow of the tracker state and its configuration
    logic [SIZE_W-1:0]  fwd_sizes [TBL_DEPTH];
    logic [SIZE_W-1:0]  ret_sizes [TBL_DEPTH];
    logic [PANEL_W-1:0] cur_panel;
    logic               ret_phase;
    logic [SIZE_W-1:0]  cur_ret_bytes;
    logic               own_pending;
    logic [PANEL_W-1:0] cfg_total;
    logic [ENTRY_W-1:0] cfg_own;

    result_t expected_slots[$];

    int cycles;
    int mismatches;
    int results_seen;
    int burst_left;
    int n_loads, n_headers, n_segs, n_noise, n_settings;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        $display("MISMATCH cycle %0d: %s", cycles, what);
        mismatches++;
    endtask

    function automatic result_t predict_slot(item_t it);
        result_t r;
        int      lim;
        int      idx;
        int      scan;
        bit      hit;
        r = '0;
        r.action = ACT_NONE;
        lim = (cfg_total > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_total);
        case (it.cmd)
            CMD_LOAD: begin
                fwd_sizes[it.entry_index] = it.entry_fwd_bytes;
                ret_sizes[it.entry_index] = it.entry_ret_bytes;
            end
            CMD_HEADER: begin
                cur_panel    = '0;
                ret_phase    = 1'b0;
                own_pending  = 1'b0;
                r.action     = ACT_RECV;
                r.byte_count = fwd_sizes[0];
            end
            CMD_SEG_DONE: begin
                idx = cur_panel;
                own_pending = 1'b0;
                if (!ret_phase) begin
                    r.own_segment = (idx == int'(cfg_own));
                    if (idx + 1 >= lim) begin
                        idx = 0;
                        ret_phase = 1'b1;
                    end
                    else begin
                        cur_panel    = PANEL_W'(idx + 1);
                        r.action     = ACT_RECV;
                        r.byte_count = fwd_sizes[cur_panel];
                    end
                end
                if (ret_phase) begin
                    // scan forward for the next panel that has return data
                    hit  = 1'b0;
                    scan = idx;
                    while (scan < lim && !hit) begin
                        if (ret_sizes[scan] != '0)
                            hit = 1'b1;
                        else
                            scan++;
                    end
                    if (hit) begin
                        cur_ret_bytes = ret_sizes[scan];
                        cur_panel     = PANEL_W'(scan + 1);
                        r.action      = (scan == int'(cfg_own)) ? ACT_OWN_SEND : ACT_RECV;
                        own_pending   = (r.action == ACT_OWN_SEND);
                        r.byte_count  = ret_sizes[scan];
                    end
                    else begin
                        cur_panel    = '0;
                        ret_phase    = 1'b0;
                        r.action     = ACT_RECV;
                        r.byte_count = fwd_sizes[0];
                    end
                end
            end
            default: ;
        endcase
        r.in_return_phase = ret_phase;
        r.next_panel      = cur_panel;
        return r;
    endfunction

    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && done) begin
            results_seen++;
            if (expected_slots.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", result));
            end
            else begin
                exp_r = expected_slots.pop_front();
                if (result.action !== exp_r.action)
                    report_mismatch($sformatf("action exp %0d got %0d",
                                              exp_r.action, result.action));
                if (result.byte_count !== exp_r.byte_count)
                    report_mismatch($sformatf("byte_count exp %0d got %0d",
                                              exp_r.byte_count, result.byte_count));
                if (result.own_segment !== exp_r.own_segment)
                    report_mismatch($sformatf("own_segment exp %0b got %0b",
                                              exp_r.own_segment, result.own_segment));
                if (result.in_return_phase !== exp_r.in_return_phase)
                    report_mismatch($sformatf("in_return_phase exp %0b got %0b",
                                              exp_r.in_return_phase, result.in_return_phase));
                if (result.next_panel !== exp_r.next_panel)
                    report_mismatch($sformatf("next_panel exp %0d got %0d",
                                              exp_r.next_panel, result.next_panel));
            end
        end
    end

    function automatic item_t make_item(cmd_t c, int idx, int fwd, int ret);
        item_t it;
        it.cmd             = c;
        it.entry_index     = ENTRY_W'(idx);
        it.entry_fwd_bytes = SIZE_W'(fwd);
        it.entry_ret_bytes = SIZE_W'(ret);
        return it;
    endfunction

    function automatic item_t rand_item(cmd_t c);
        // return sizes are often zero so the scan has panels to skip
        return make_item(c, $urandom_range(0, TBL_DEPTH - 1), $urandom_range(0, 8191),
                         ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8191));
    endfunction

    task automatic send_cmd(item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy !== 1'b0);
        expected_slots.push_back(predict_slot(it));
        case (it.cmd)
            CMD_LOAD:     n_loads++;
            CMD_HEADER:   n_headers++;
            CMD_SEG_DONE: n_segs++;
            default:      n_noise++;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Drop start and wait until every transfer has produced its result
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (expected_slots.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TOTAL_PANELS)
            cfg_total = val;
        else
            cfg_own = val[ENTRY_W-1:0];
        n_settings++;
    endtask

    task automatic apply_reset();
        cur_panel     = '0;
        ret_phase     = 1'b0;
        cur_ret_bytes = '0;
        own_pending   = 1'b0;
        cfg_total     = PANEL_W'(1);
        cfg_own       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
    endtask

    // Three panels, this one at position 1: full forward pass, return scan with
    // own slot, header in the middle of the return phase
    task automatic test_single_pass();
        settle();
        cfg_write(CFG_TOTAL_PANELS, CFG_W'(3));
        cfg_write(CFG_OWN_ADDRESS, CFG_W'(1));
        send_cmd(make_item(CMD_LOAD, 0, 8191, 0));
        send_cmd(make_item(CMD_LOAD, 1, 0, 8191));
        send_cmd(make_item(CMD_LOAD, 2, 'h1555, 'h0AAA));
        send_cmd(make_item(CMD_LOAD, 63, 'h0AAA, 'h1555));
        send_cmd(make_item(CMD_UNUSED, 63, 8191, 8191));
        send_cmd(make_item(CMD_HEADER, 0, 0, 0));
        repeat (3) send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        send_cmd(make_item(CMD_SEG_DONE, 63, 8191, 8191));
        send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        repeat (3) send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        send_cmd(make_item(CMD_UNUSED, 0, 0, 0));
        send_cmd(make_item(CMD_HEADER, 42, 'h1234, 'h0567));
    endtask

    // Panel counts of zero and one
    task automatic test_panel_count_edges();
        settle();
        cfg_write(CFG_TOTAL_PANELS, CFG_W'(0));
        send_cmd(make_item(CMD_HEADER, 0, 0, 0));
        send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        settle();
        cfg_write(CFG_TOTAL_PANELS, CFG_W'(1));
        cfg_write(CFG_OWN_ADDRESS, CFG_W'(0));
        send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        send_cmd(make_item(CMD_LOAD, 0, 0, 8191));
        send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        send_cmd(make_item(CMD_SEG_DONE, 0, 0, 0));
        send_cmd(make_item(CMD_HEADER, 0, 0, 0));
    endtask

    task automatic test_random_traffic();
        int order[TBL_DEPTH];
        int totals[12] = '{2, 127, 0, 5, 1, 64, 3, 8, 4, 6, 2, 3};
        int tmp, j, lim, own, n_items, hdr_pct, sent, pick;
        // fill the whole table first so no later scan touches an unloaded entry
        for (int i = 0; i < TBL_DEPTH; i++)
            order[i] = i;
        for (int i = TBL_DEPTH - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < TBL_DEPTH; i++)
            send_cmd(make_item(CMD_LOAD, order[i], $urandom_range(0, 8191),
                               ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8191)));
        for (int p = 0; p < 12; p++) begin
            settle();
            cfg_write(CFG_TOTAL_PANELS, CFG_W'(totals[p]));
            lim = (totals[p] > TBL_DEPTH) ? TBL_DEPTH : totals[p];
            case (p % 3)
                0:       own = 0;
                1:       own = TBL_DEPTH - 1;
                default: own = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
            endcase
            cfg_write(CFG_OWN_ADDRESS, CFG_W'(own));
            // long chains need rare headers or the return phase is never reached
            n_items = (lim > 16) ? 170 : 60;
            hdr_pct = (lim > 16) ? 1 : 6;
            send_cmd(rand_item(CMD_HEADER));
            sent = 1;
            while (sent < n_items) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_cmd(rand_item(CMD_UNUSED));
                end
                else begin
                    if (pick < 10)
                        send_cmd(rand_item(CMD_LOAD));
                    else if (pick < 10 + hdr_pct)
                        send_cmd(rand_item(CMD_HEADER));
                    else
                        send_cmd(rand_item(CMD_SEG_DONE));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int waited;
        cycles       = 0;
        mismatches   = 0;
        results_seen = 0;
        burst_left   = 0;
        waited       = 0;
        apply_reset();
        test_single_pass();
        test_panel_count_edges();
        test_random_traffic();

        @(negedge clk);
        start <= 1'b0;
        while (expected_slots.size() != 0 && waited < 5000) begin
            @(posedge clk);
            waited++;
        end
        repeat (80) @(posedge clk);
        if (expected_slots.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_slots.size()));

        $display("Sent %0d loads, %0d headers, %0d segment ends, %0d unused commands",
                 n_loads, n_headers, n_segs, n_noise);
        $display("Checked %0d results across %0d register writes in %0d cycles",
                 results_seen, n_settings, cycles);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
rtl/cst_pkg.sv
rtl/cst_table.sv
rtl/cst_seq.sv
rtl/chain_slot_tracker.sv
rtl/cst_checker.sv
verif/tb.sv
